// File: hw/rtl/utf8_text_quality_scorer_macros.svh
// Assertion helpers for the text quality scorer.
// Both macros sample on the rising edge of clock and are off while reset is high.
`ifndef UTF8_TEXT_QUALITY_SCORER_MACROS_SVH
`define UTF8_TEXT_QUALITY_SCORER_MACROS_SVH

// Same-cycle implication.
`define UTQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utq: same-cycle check failed");

// Next-cycle implication.
`define UTQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utq: next-cycle check failed");

`endif

// File: hw/rtl/utq_pkg.sv
package utq_pkg;

   // Flags carried with a finished field
   typedef struct packed {
      logic space_seen;
      logic multibyte_seen;
   } utq_flags_type;

   // UTF-8 byte classes
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // ASCII codes of interest
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

   // Scoring weights
   localparam logic signed [7:0] SCORE_BASE      = 8'sd50;
   localparam logic signed [7:0] BONUS_HIGH      = 8'sd20;
   localparam logic signed [7:0] BONUS_LOW       = 8'sd10;
   localparam logic signed [7:0] BONUS_SPACE     = 8'sd10;
   localparam logic signed [7:0] BONUS_MULTIBYTE = 8'sd15;
   localparam logic signed [7:0] PENALTY_CONTROL = 8'sd30;
   localparam logic signed [7:0] PENALTY_OTHER   = 8'sd20;
   localparam logic [6:0]        SCORE_MAX       = 7'd100;

endpackage

// File: hw/rtl/utf8_text_quality_scorer.sv
// UTF-8 text quality scorer.
// Request channel (req_valid/req_ready): one byte of a text field per beat in
// req_byte_value; req_last_byte marks the field's final byte. Fields are never
// empty. A zero byte ends scanning; later bytes of that field are ignored.
// Response channel (rsp_valid/rsp_ready): one beat per field, rsp_quality_score
// in 0..100; a field with no decoded characters scores 0.
// Throughput: one byte per cycle while req_ready is high. Each accepted byte
// updates the counters and the pending-sequence tracker at the edge that accepts it.
// Path: a field's result goes through the snapshot register, which loads at the edge
// that accepts the last byte, and then the output register, which drives rsp_valid.
// Stall: a held response keeps its value; the snapshot register takes one
// more finished field, and req_ready drops only when both registers are full.
// Reset (synchronous, active high) clears all field state and both valids.
// Counters saturate at 2*MAX_BYTES-1.
module utf8_text_quality_scorer #(
   parameter int MAX_BYTES = 65536
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_quality_score
);
   import utq_pkg::*;

   localparam int CountWidth = $clog2(2 * MAX_BYTES);

   logic                  snap_valid, snap_ready;
   logic [CountWidth-1:0] snap_printable, snap_letter, snap_control, snap_char, snap_byte;
   utq_flags_type         snap_flags;

   utq_accum #(
      .MAX_BYTES (MAX_BYTES),
      .CountWidth(CountWidth)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_value(req_byte_value),
      .req_last_byte (req_last_byte),
      .snap_ready    (snap_ready),
      .snap_valid    (snap_valid),
      .snap_printable(snap_printable),
      .snap_letter   (snap_letter),
      .snap_control  (snap_control),
      .snap_char     (snap_char),
      .snap_byte     (snap_byte),
      .snap_flags    (snap_flags)
   );

   utq_score #(
      .CountWidth(CountWidth)
   ) u_score (
      .clock            (clock),
      .reset            (reset),
      .snap_valid       (snap_valid),
      .snap_ready       (snap_ready),
      .snap_printable   (snap_printable),
      .snap_letter      (snap_letter),
      .snap_control     (snap_control),
      .snap_char        (snap_char),
      .snap_byte        (snap_byte),
      .snap_flags       (snap_flags),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_quality_score(rsp_quality_score)
   );

endmodule

// File: hw/rtl/utq_accum.sv
module utq_accum #(
   parameter int MAX_BYTES = 65536,
   parameter int CountWidth = 17
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_byte_value,
   input  logic                      req_last_byte,
   input  logic                      snap_ready,
   output logic                      snap_valid,
   output logic [CountWidth-1:0]     snap_printable,
   output logic [CountWidth-1:0]     snap_letter,
   output logic [CountWidth-1:0]     snap_control,
   output logic [CountWidth-1:0]     snap_char,
   output logic [CountWidth-1:0]     snap_byte,
   output utq_pkg::utq_flags_type    snap_flags
);
   import utq_pkg::*;

   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(2 * MAX_BYTES - 1);

   // Saturating add; amounts never exceed four
   function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] cnt,
                                                     input logic [2:0] amt);
      logic [CountWidth:0] sum;
      sum = {1'b0, cnt} + (CountWidth + 1)'(amt);
      return (sum >= {1'b0, CountLimit}) ? CountLimit : sum[CountWidth-1:0];
   endfunction

   logic [1:0]            need_ff, need_in, gath_ff, gath_in, gath_inc;
   logic                  term_ff, term_in;
   logic                  space_ff, space_in, mb_ff, mb_in;
   logic [CountWidth-1:0] print_ff, print_in, letter_ff, letter_in;
   logic [CountWidth-1:0] ctrl_ff, ctrl_in, char_ff, char_in, byte_ff, byte_in;
   logic                  inc_byte, inc_char, inc_print, inc_letter;
   logic [2:0]            inc_ctrl;
   logic                  accept, snap_valid_ff, snap_valid_in;
   logic [CountWidth-1:0] snap_print_ff, snap_letter_ff, snap_ctrl_ff;
   logic [CountWidth-1:0] snap_char_ff, snap_byte_ff;
   utq_flags_type         snap_flags_ff;
   logic [7:0]            b;

   assign b         = req_byte_value;
   assign req_ready = !snap_valid_ff || snap_ready;
   assign accept    = req_valid && req_ready;

   // Per-beat decode and counter increments
   always_comb begin
      need_in    = need_ff;
      gath_in    = gath_ff;
      term_in    = term_ff;
      space_in   = space_ff;
      mb_in      = mb_ff;
      inc_byte   = 1'b0;
      inc_char   = 1'b0;
      inc_print  = 1'b0;
      inc_letter = 1'b0;
      inc_ctrl   = 3'd0;
      gath_inc   = gath_ff + 2'd1;
      if (!term_ff) begin
         if (need_ff != 2'd0 && (b & CONT_MASK) == CONT_TAG) begin
            // continuation of a pending sequence
            inc_byte = 1'b1;
            if (gath_inc >= need_ff) begin
               inc_char   = 1'b1;
               inc_print  = 1'b1;
               inc_letter = 1'b1;
               mb_in      = 1'b1;
               need_in    = 2'd0;
               gath_in    = 2'd0;
            end else begin
               gath_in = gath_inc;
            end
         end else begin
            // broken sequence: lead plus gathered bytes count as control
            if (need_ff != 2'd0) begin
               inc_ctrl = 3'd1 + {1'b0, gath_ff};
            end
            need_in = 2'd0;
            gath_in = 2'd0;
            if (b == CHAR_NUL) begin
               term_in = 1'b1;
            end else begin
               inc_byte = 1'b1;
               if (!b[7]) begin
                  inc_char = 1'b1;
                  if (b >= CHAR_SPACE) begin
                     inc_print = 1'b1;
                     if ((b >= CHAR_UC_A && b <= CHAR_UC_Z) ||
                         (b >= CHAR_LC_A && b <= CHAR_LC_Z)) begin
                        inc_letter = 1'b1;
                     end else if (b == CHAR_SPACE) begin
                        space_in = 1'b1;
                     end
                  end else if (b != CHAR_LF && b != CHAR_CR && b != CHAR_TAB) begin
                     inc_ctrl = inc_ctrl + 3'd1;
                  end
               end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                  need_in = 2'd1;
               end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                  need_in = 2'd2;
               end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                  need_in = 2'd3;
               end else begin
                  inc_ctrl = inc_ctrl + 3'd1;
               end
            end
         end
      end
      // field ends mid-sequence
      if (req_last_byte && need_in != 2'd0) begin
         inc_ctrl = inc_ctrl + 3'd1 + {1'b0, gath_in};
      end
      print_in  = sat_add(print_ff,  {2'b00, inc_print});
      letter_in = sat_add(letter_ff, {2'b00, inc_letter});
      ctrl_in   = sat_add(ctrl_ff,   inc_ctrl);
      char_in   = sat_add(char_ff,   {2'b00, inc_char});
      byte_in   = sat_add(byte_ff,   {2'b00, inc_byte});
   end

   assign snap_valid_in = (snap_valid_ff && !snap_ready) || (accept && req_last_byte);

   // Field state; cleared at the end of each field
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         need_ff   <= 2'd0;
         gath_ff   <= 2'd0;
         term_ff   <= 1'b0;
         space_ff  <= 1'b0;
         mb_ff     <= 1'b0;
         print_ff  <= '0;
         letter_ff <= '0;
         ctrl_ff   <= '0;
         char_ff   <= '0;
         byte_ff   <= '0;
      end else if (accept) begin
         need_ff   <= need_in;
         gath_ff   <= gath_in;
         term_ff   <= term_in;
         space_ff  <= space_in;
         mb_ff     <= mb_in;
         print_ff  <= print_in;
         letter_ff <= letter_in;
         ctrl_ff   <= ctrl_in;
         char_ff   <= char_in;
         byte_ff   <= byte_in;
      end
   end

   // Snapshot register handed to the scoring stage
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         snap_print_ff                <= print_in;
         snap_letter_ff               <= letter_in;
         snap_ctrl_ff                 <= ctrl_in;
         snap_char_ff                 <= char_in;
         snap_byte_ff                 <= byte_in;
         snap_flags_ff.space_seen     <= space_in;
         snap_flags_ff.multibyte_seen <= mb_in;
      end
   end

   assign snap_valid     = snap_valid_ff;
   assign snap_printable = snap_print_ff;
   assign snap_letter    = snap_letter_ff;
   assign snap_control   = snap_ctrl_ff;
   assign snap_char      = snap_char_ff;
   assign snap_byte      = snap_byte_ff;
   assign snap_flags     = snap_flags_ff;

endmodule

// File: hw/rtl/utq_score.sv
module utq_score #(
   parameter int CountWidth = 17
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      snap_valid,
   output logic                      snap_ready,
   input  logic [CountWidth-1:0]     snap_printable,
   input  logic [CountWidth-1:0]     snap_letter,
   input  logic [CountWidth-1:0]     snap_control,
   input  logic [CountWidth-1:0]     snap_char,
   input  logic [CountWidth-1:0]     snap_byte,
   input  utq_pkg::utq_flags_type    snap_flags,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [6:0]                rsp_quality_score
);
   import utq_pkg::*;

   // room for twenty times a count
   localparam int ExtWidth = CountWidth + 5;

   logic [ExtWidth-1:0] p, l, c, t, n;
   logic signed [7:0]   sc;
   logic [6:0]          score_in, score_ff;
   logic                rsp_valid_ff;

   assign p = ExtWidth'(snap_printable);
   assign l = ExtWidth'(snap_letter);
   assign c = ExtWidth'(snap_control);
   assign t = ExtWidth'(snap_char);
   assign n = ExtWidth'(snap_byte);

   // Ratio tests as constant cross-multiplications, then clamp
   always_comb begin
      sc = SCORE_BASE;
      if (p * ExtWidth'(5) > t * ExtWidth'(4)) begin
         sc = sc + BONUS_HIGH;
      end else if (p * ExtWidth'(5) > t * ExtWidth'(3)) begin
         sc = sc + BONUS_LOW;
      end
      if (l * ExtWidth'(10) > t * ExtWidth'(3)) begin
         sc = sc + BONUS_HIGH;
      end else if (l * ExtWidth'(10) > t) begin
         sc = sc + BONUS_LOW;
      end
      if (snap_flags.space_seen && n > ExtWidth'(10)) begin
         sc = sc + BONUS_SPACE;
      end
      if (snap_flags.multibyte_seen) begin
         sc = sc + BONUS_MULTIBYTE;
      end
      if (c * ExtWidth'(10) > n) begin
         sc = sc - PENALTY_CONTROL;
      end
      if (p * ExtWidth'(2) < t) begin
         sc = sc - PENALTY_OTHER;
      end
      if (l * ExtWidth'(20) < t && !snap_flags.multibyte_seen) begin
         sc = sc - PENALTY_OTHER;
      end
      if (n < ExtWidth'(3)) begin
         sc = sc - PENALTY_OTHER;
      end
      if (t == '0 || sc < 8'sd0) begin
         score_in = 7'd0;
      end else if (sc > $signed({1'b0, SCORE_MAX})) begin
         score_in = SCORE_MAX;
      end else begin
         score_in = sc[6:0];
      end
   end

   assign snap_ready = !rsp_valid_ff || rsp_ready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_ready && snap_valid) begin
         score_ff <= score_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_quality_score = score_ff;

endmodule

// File: hw/rtl/utq_checker.sv
`include "utf8_text_quality_scorer_macros.svh"

module utq_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_quality_score
);
   import utq_pkg::*;

   // score is always clamped
   `UTQ_ASSERT_IMPL(a_score_range, rsp_valid, rsp_quality_score <= SCORE_MAX)

   // nothing left over right after reset
   `UTQ_ASSERT_IMPL(a_idle_after_reset, $past(reset), !rsp_valid)

   // request side backs up only when the output register holds a stalled response
   `UTQ_ASSERT_IMPL(a_ready_only_when_full, !req_ready, rsp_valid && !rsp_ready)

   // stalled response beat holds
   `UTQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_quality_score))

endmodule

bind utf8_text_quality_scorer utq_checker u_utq_checker (.*);
